// ===== sv/y2rgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2rgb_pkg
// Shared widths, coefficients and stage types for the YUYV to RGB888 unit.
// ----------------------------------------------------------------------------
package y2rgb_pkg;

	localparam int PIX_W  = 8;   // luma, chroma and output channel width
	localparam int DIFF_W = 9;   // chroma minus offset, signed
	localparam int FRAC_W = 20;  // fraction bits of the coefficients
	localparam int PROD_W = 30;  // coefficient times chroma difference, signed
	localparam int TERM_W = PROD_W - FRAC_W; // chroma term after floor shift
	localparam int CH_W   = 11;  // luma plus term before clamping, signed

	localparam logic signed [PROD_W-1:0] COEF_RV = 30'sd1437289;
	localparam logic signed [PROD_W-1:0] COEF_GV = 30'sd731907;
	localparam logic signed [PROD_W-1:0] COEF_GU = 30'sd354034;
	localparam logic signed [PROD_W-1:0] COEF_BU = 30'sd1816601;

	localparam logic signed [DIFF_W-1:0] CHROMA_OFFSET = 9'sd128;
	localparam logic [PIX_W-1:0]         SCALE_NUM     = 8'd220;
	localparam logic [PIX_W-1:0]         CH_MAX        = 8'd255;
	localparam logic [PIX_W-1:0]         OUT_MAX       = 8'd219;

	// Chroma front end to pixel back end
	typedef struct packed {
		logic                     valid;
		logic                     frame_end;
		logic [PIX_W-1:0]         y_first;
		logic [PIX_W-1:0]         y_second;
		logic signed [TERM_W-1:0] r_term;
		logic signed [TERM_W-1:0] g_term;
		logic signed [TERM_W-1:0] b_term;
	} chroma_stage_t;

	// Finished macropixel
	typedef struct packed {
		logic             valid;
		logic             frame_end;
		logic [PIX_W-1:0] red_first;
		logic [PIX_W-1:0] green_first;
		logic [PIX_W-1:0] blue_first;
		logic [PIX_W-1:0] red_second;
		logic [PIX_W-1:0] green_second;
		logic [PIX_W-1:0] blue_second;
	} result_t;

endpackage

// ===== sv/yuyv_to_rgb888_scaled_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb888_scaled_unit
// One YUYV macropixel in, two scaled RGB888 pixels out, frame-end passed on.
// ----------------------------------------------------------------------------
// Pipeline: five register stages; done and the result ports are driven
//   directly from the fifth stage.
// Throughput: one macropixel per cycle; busy is always low, since the
//   result strobe cannot be held off and the pipeline never stalls.
// Reset: arst_n clears the valid bits of all five stages; data registers
//   are not reset and no spurious done follows reset.
// ----------------------------------------------------------------------------
module yuyv_to_rgb888_scaled_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [y2rgb_pkg::PIX_W-1:0] luma_first,
	input  logic [y2rgb_pkg::PIX_W-1:0] chroma_blue,
	input  logic [y2rgb_pkg::PIX_W-1:0] luma_second,
	input  logic [y2rgb_pkg::PIX_W-1:0] chroma_red,
	input  logic                        frame_end_in,
	output logic                        done,
	output logic [y2rgb_pkg::PIX_W-1:0] red_first,
	output logic [y2rgb_pkg::PIX_W-1:0] green_first,
	output logic [y2rgb_pkg::PIX_W-1:0] blue_first,
	output logic [y2rgb_pkg::PIX_W-1:0] red_second,
	output logic [y2rgb_pkg::PIX_W-1:0] green_second,
	output logic [y2rgb_pkg::PIX_W-1:0] blue_second,
	output logic                        frame_end_out
);

	// Stage map:
	//   s1  register inputs, U-128 and V-128
	//   s2  four coefficient products (one 30x9 multiply each)
	//   s3  green product sum, floor shift by 20 (upper bits)
	//   s4  luma plus/minus term, clamp to 0..255, both pixels
	//   s5  x220 >> 8, drives the result ports directly

	y2rgb_pkg::chroma_stage_t chroma_stage;
	y2rgb_pkg::result_t       result;
	logic                     accept;

	// every cycle can take a transfer
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	y2rgb_chroma u_chroma (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (accept),
		.luma_first   (luma_first),
		.chroma_blue  (chroma_blue),
		.luma_second  (luma_second),
		.chroma_red   (chroma_red),
		.frame_end_in (frame_end_in),
		.stage_out    (chroma_stage)
	);

	y2rgb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage_in (chroma_stage),
		.result   (result)
	);

	// result transfer: one cycle per macropixel, marked by done
	assign done          = result.valid;
	assign frame_end_out = result.frame_end;
	assign red_first     = result.red_first;
	assign green_first   = result.green_first;
	assign blue_first    = result.blue_first;
	assign red_second    = result.red_second;
	assign green_second  = result.green_second;
	assign blue_second   = result.blue_second;

endmodule

// ===== sv/y2rgb_chroma.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2rgb_chroma
// Stages 1-3: chroma offset removal, coefficient products, floor-shifted terms.
// ----------------------------------------------------------------------------
module y2rgb_chroma (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [y2rgb_pkg::PIX_W-1:0]    luma_first,
	input  logic [y2rgb_pkg::PIX_W-1:0]    chroma_blue,
	input  logic [y2rgb_pkg::PIX_W-1:0]    luma_second,
	input  logic [y2rgb_pkg::PIX_W-1:0]    chroma_red,
	input  logic                           frame_end_in,
	output y2rgb_pkg::chroma_stage_t       stage_out
);

	// stage 1: captured inputs, chroma differences
	logic                                  valid_s1;
	logic                                  fe_s1;
	logic [y2rgb_pkg::PIX_W-1:0]           y0_s1, y1_s1;
	logic signed [y2rgb_pkg::DIFF_W-1:0]   du_s1, dv_s1;

	// stage 2: products
	logic                                  valid_s2;
	logic                                  fe_s2;
	logic [y2rgb_pkg::PIX_W-1:0]           y0_s2, y1_s2;
	logic signed [y2rgb_pkg::PROD_W-1:0]   rv_s2, gv_s2, gu_s2, bu_s2;

	// stage 3: terms
	logic                                  valid_s3;
	logic                                  fe_s3;
	logic [y2rgb_pkg::PIX_W-1:0]           y0_s3, y1_s3;
	logic signed [y2rgb_pkg::TERM_W-1:0]   rt_s3, gt_s3, bt_s3;

	logic signed [y2rgb_pkg::DIFF_W-1:0]   du_c, dv_c;
	logic signed [y2rgb_pkg::PROD_W-1:0]   g_sum_c;

	assign du_c = $signed({1'b0, chroma_blue}) - y2rgb_pkg::CHROMA_OFFSET;
	assign dv_c = $signed({1'b0, chroma_red}) - y2rgb_pkg::CHROMA_OFFSET;

	// no overflow: |sum| < 2^28
	assign g_sum_c = gv_s2 + gu_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		fe_s1 <= frame_end_in;
		y0_s1 <= luma_first;
		y1_s1 <= luma_second;
		du_s1 <= du_c;
		dv_s1 <= dv_c;

		fe_s2 <= fe_s1;
		y0_s2 <= y0_s1;
		y1_s2 <= y1_s1;
		rv_s2 <= y2rgb_pkg::COEF_RV * y2rgb_pkg::PROD_W'(dv_s1);
		gv_s2 <= y2rgb_pkg::COEF_GV * y2rgb_pkg::PROD_W'(dv_s1);
		gu_s2 <= y2rgb_pkg::COEF_GU * y2rgb_pkg::PROD_W'(du_s1);
		bu_s2 <= y2rgb_pkg::COEF_BU * y2rgb_pkg::PROD_W'(du_s1);

		// upper bits of a signed value are its floor shift
		fe_s3 <= fe_s2;
		y0_s3 <= y0_s2;
		y1_s3 <= y1_s2;
		rt_s3 <= rv_s2[y2rgb_pkg::PROD_W-1:y2rgb_pkg::FRAC_W];
		gt_s3 <= g_sum_c[y2rgb_pkg::PROD_W-1:y2rgb_pkg::FRAC_W];
		bt_s3 <= bu_s2[y2rgb_pkg::PROD_W-1:y2rgb_pkg::FRAC_W];
	end

	assign stage_out.valid     = valid_s3;
	assign stage_out.frame_end = fe_s3;
	assign stage_out.y_first   = y0_s3;
	assign stage_out.y_second  = y1_s3;
	assign stage_out.r_term    = rt_s3;
	assign stage_out.g_term    = gt_s3;
	assign stage_out.b_term    = bt_s3;

	// term magnitudes bounded by coefficient * 128 / 2^20
	a_r_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (rt_s3 >= -10'sd176 && rt_s3 <= 10'sd175))
		else $error("red chroma term out of range");

	a_b_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (bt_s3 >= -10'sd222 && bt_s3 <= 10'sd221))
		else $error("blue chroma term out of range");

endmodule

// ===== sv/y2rgb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2rgb_back
// Stages 4-5: add luma, clamp to 0..255, scale by 220/256 for both pixels.
// ----------------------------------------------------------------------------
module y2rgb_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  y2rgb_pkg::chroma_stage_t stage_in,
	output y2rgb_pkg::result_t       result
);

	function automatic logic [y2rgb_pkg::PIX_W-1:0] clamp_ch(
		input logic signed [y2rgb_pkg::CH_W-1:0] ch
	);
		logic [y2rgb_pkg::PIX_W-1:0] res;
		if (ch[y2rgb_pkg::CH_W-1])
			res = '0;
		else if (ch[y2rgb_pkg::CH_W-2:y2rgb_pkg::PIX_W] != '0)
			res = y2rgb_pkg::CH_MAX;
		else
			res = ch[y2rgb_pkg::PIX_W-1:0];
		return res;
	endfunction

	function automatic logic [y2rgb_pkg::PIX_W-1:0] scale_ch(
		input logic [y2rgb_pkg::PIX_W-1:0] c
	);
		logic [2*y2rgb_pkg::PIX_W-1:0] prod;
		prod = (2*y2rgb_pkg::PIX_W)'(c) * (2*y2rgb_pkg::PIX_W)'(y2rgb_pkg::SCALE_NUM);
		return prod[2*y2rgb_pkg::PIX_W-1:y2rgb_pkg::PIX_W];
	endfunction

	logic signed [y2rgb_pkg::CH_W-1:0] y0_c, y1_c;
	logic signed [y2rgb_pkg::CH_W-1:0] rt_c, gt_c, bt_c;

	logic                              valid_s4, valid_s5;
	logic                              fe_s4, fe_s5;
	logic [y2rgb_pkg::PIX_W-1:0]       r0_s4, g0_s4, b0_s4, r1_s4, g1_s4, b1_s4;
	logic [y2rgb_pkg::PIX_W-1:0]       r0_s5, g0_s5, b0_s5, r1_s5, g1_s5, b1_s5;

	assign y0_c = $signed({3'b000, stage_in.y_first});
	assign y1_c = $signed({3'b000, stage_in.y_second});
	assign rt_c = y2rgb_pkg::CH_W'(stage_in.r_term);
	assign gt_c = y2rgb_pkg::CH_W'(stage_in.g_term);
	assign bt_c = y2rgb_pkg::CH_W'(stage_in.b_term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= stage_in.valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		fe_s4 <= stage_in.frame_end;
		r0_s4 <= clamp_ch(y0_c + rt_c);
		g0_s4 <= clamp_ch(y0_c - gt_c);
		b0_s4 <= clamp_ch(y0_c + bt_c);
		r1_s4 <= clamp_ch(y1_c + rt_c);
		g1_s4 <= clamp_ch(y1_c - gt_c);
		b1_s4 <= clamp_ch(y1_c + bt_c);

		fe_s5 <= fe_s4;
		r0_s5 <= scale_ch(r0_s4);
		g0_s5 <= scale_ch(g0_s4);
		b0_s5 <= scale_ch(b0_s4);
		r1_s5 <= scale_ch(r1_s4);
		g1_s5 <= scale_ch(g1_s4);
		b1_s5 <= scale_ch(b1_s4);
	end

	assign result.valid        = valid_s5;
	assign result.frame_end    = fe_s5;
	assign result.red_first    = r0_s5;
	assign result.green_first  = g0_s5;
	assign result.blue_first   = b0_s5;
	assign result.red_second   = r1_s5;
	assign result.green_second = g1_s5;
	assign result.blue_second  = b1_s5;

	a_first_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (r0_s5 <= y2rgb_pkg::OUT_MAX && g0_s5 <= y2rgb_pkg::OUT_MAX
			&& b0_s5 <= y2rgb_pkg::OUT_MAX))
		else $error("first pixel channel above scaled maximum");

	a_second_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (r1_s5 <= y2rgb_pkg::OUT_MAX && g1_s5 <= y2rgb_pkg::OUT_MAX
			&& b1_s5 <= y2rgb_pkg::OUT_MAX))
		else $error("second pixel channel above scaled maximum");

endmodule

// ===== test/tb_yuyv_to_rgb888_scaled_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuyv_to_rgb888_scaled_unit
// Self-checking bench for the YUYV macropixel to scaled RGB888 converter.
// Directed corner words, then random words in phases of different sender
// idling. Every accepted word is predicted in fixed point and every done
// strobe is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_yuyv_to_rgb888_scaled_unit;

	localparam int PIX_W = y2rgb_pkg::PIX_W;

	// Conversion constants: coefficients carry 20 fraction bits
	localparam longint K_RED_V   = 1437289;
	localparam longint K_GREEN_V = 731907;
	localparam longint K_GREEN_U = 354034;
	localparam longint K_BLUE_U  = 1816601;
	localparam int     FRAC_BITS = 20;
	localparam longint UV_BIAS   = 128;
	localparam longint OUT_SCALE = 220;
	localparam int     MAX_SHOWN = 10;     // mismatches printed in full
	localparam int     DRAIN_CYC = 10;     // pipeline is 5 deep, keep margin
	localparam int     END_LIMIT = 200;    // cycles allowed for the last results

	// One input transfer
	typedef struct packed {
		logic [PIX_W-1:0] luma_first;
		logic [PIX_W-1:0] chroma_blue;
		logic [PIX_W-1:0] luma_second;
		logic [PIX_W-1:0] chroma_red;
		logic             frame_end;
	} yuyv_word_t;

	// One result transfer: two pixels plus the frame-end copy
	typedef struct packed {
		logic [PIX_W-1:0] red_first;
		logic [PIX_W-1:0] green_first;
		logic [PIX_W-1:0] blue_first;
		logic [PIX_W-1:0] red_second;
		logic [PIX_W-1:0] green_second;
		logic [PIX_W-1:0] blue_second;
		logic             frame_end;
	} rgb_pair_t;

	// Predicts the pixel pair of each accepted word and checks the results
	// against the oldest prediction.
	class rgb_scoreboard;
		rgb_pair_t   pending_rgb[$];
		int unsigned words_in;
		int unsigned pairs_checked;
		int unsigned frame_marks;
		int unsigned clamped_channels;
		int unsigned failures;

		function logic [PIX_W-1:0] clamp_scale(longint chan);
			longint sat;
			sat = chan;
			if (chan < 0 || chan > 255) begin
				clamped_channels++;
			end
			if (sat < 0) begin
				sat = 0;
			end
			if (sat > 255) begin
				sat = 255;
			end
			return PIX_W'((sat * OUT_SCALE) >> 8);
		endfunction

		// Chroma terms are shared by both pixels; >>> on a signed longint
		// is a floor shift, matching the upper-bit slices in the design.
		function rgb_pair_t convert_macropixel(yuyv_word_t w);
			rgb_pair_t p;
			longint    du, dv, red_term, green_term, blue_term, y0, y1;
			du         = longint'(w.chroma_blue) - UV_BIAS;
			dv         = longint'(w.chroma_red) - UV_BIAS;
			y0         = longint'(w.luma_first);
			y1         = longint'(w.luma_second);
			red_term   = (K_RED_V * dv) >>> FRAC_BITS;
			green_term = (K_GREEN_V * dv + K_GREEN_U * du) >>> FRAC_BITS;
			blue_term  = (K_BLUE_U * du) >>> FRAC_BITS;
			p.red_first    = clamp_scale(y0 + red_term);
			p.green_first  = clamp_scale(y0 - green_term);
			p.blue_first   = clamp_scale(y0 + blue_term);
			p.red_second   = clamp_scale(y1 + red_term);
			p.green_second = clamp_scale(y1 - green_term);
			p.blue_second  = clamp_scale(y1 + blue_term);
			p.frame_end    = w.frame_end;
			return p;
		endfunction

		function void note_input(yuyv_word_t w);
			words_in++;
			if (w.frame_end) begin
				frame_marks++;
			end
			pending_rgb.push_back(convert_macropixel(w));
		endfunction

		function void compare_field(string field, int want, int got);
			if (want != got) begin
				failures++;
				if (failures <= MAX_SHOWN) begin
					$display("%0t: %s mismatch, expected %0d, got %0d",
						$realtime, field, want, got);
				end
			end
		endfunction

		function void check_result(rgb_pair_t got);
			rgb_pair_t want;
			if (pending_rgb.size() == 0) begin
				failures++;
				if (failures <= MAX_SHOWN) begin
					$display("%0t: result with nothing outstanding", $realtime);
				end
				return;
			end
			want = pending_rgb.pop_front();
			pairs_checked++;
			compare_field("red_first",     want.red_first,    got.red_first);
			compare_field("green_first",   want.green_first,  got.green_first);
			compare_field("blue_first",    want.blue_first,   got.blue_first);
			compare_field("red_second",    want.red_second,   got.red_second);
			compare_field("green_second",  want.green_second, got.green_second);
			compare_field("blue_second",   want.blue_second,  got.blue_second);
			compare_field("frame_end_out", want.frame_end,    got.frame_end);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [PIX_W-1:0] luma_first;
	logic [PIX_W-1:0] chroma_blue;
	logic [PIX_W-1:0] luma_second;
	logic [PIX_W-1:0] chroma_red;
	logic             frame_end_in;
	logic             done;
	logic [PIX_W-1:0] red_first;
	logic [PIX_W-1:0] green_first;
	logic [PIX_W-1:0] blue_first;
	logic [PIX_W-1:0] red_second;
	logic [PIX_W-1:0] green_second;
	logic [PIX_W-1:0] blue_second;
	logic             frame_end_out;

	rgb_scoreboard sb = new();

	yuyv_to_rgb888_scaled_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.luma_first   (luma_first),
		.chroma_blue  (chroma_blue),
		.luma_second  (luma_second),
		.chroma_red   (chroma_red),
		.frame_end_in (frame_end_in),
		.done         (done),
		.red_first    (red_first),
		.green_first  (green_first),
		.blue_first   (blue_first),
		.red_second   (red_second),
		.green_second (green_second),
		.blue_second  (blue_second),
		.frame_end_out(frame_end_out)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Monitor. Everything is read at the rising edge, before the edge's
	// nonblocking updates land, so these are the values the block sampled.
	// A transfer in is start with busy low; done is checked even in reset so
	// that a stray strobe shows up as an unexpected result.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sb.note_input('{luma_first, chroma_blue, luma_second, chroma_red,
				frame_end_in});
		end
		if (done) begin
			sb.check_result('{red_first, green_first, blue_first, red_second,
				green_second, blue_second, frame_end_out});
		end
	end

	// Present one word and hold it until the block takes it. Idle cycles
	// come before the word, drawn per cycle at idle_pct percent. start is
	// assigned once per edge, so back-to-back words keep it high.
	task automatic send_word(input logic [PIX_W-1:0] y0, input logic [PIX_W-1:0] u,
		input logic [PIX_W-1:0] y1, input logic [PIX_W-1:0] v,
		input logic fe, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start        <= 1'b1;
		luma_first   <= y0;
		chroma_blue  <= u;
		luma_second  <= y1;
		chroma_red   <= v;
		frame_end_in <= fe;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	// Byte with extra weight on the edges of the range and around the
	// chroma bias, where clamping and floor rounding bite.
	function automatic logic [PIX_W-1:0] pick_byte();
		logic [PIX_W-1:0] corner [7];
		corner = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
		if ($urandom_range(9) < 7) begin
			return PIX_W'($urandom_range(255));
		end
		return corner[$urandom_range(6)];
	endfunction

	task automatic random_words(input int count, input int idle_pct);
		for (int i = 0; i < count; i++) begin
			send_word(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
				$urandom_range(15) == 0, idle_pct);
		end
	endtask

	// Stop sending until every outstanding pair has come back
	task automatic drain_pause();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_rgb.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int waited;
		arst_n       = 1'b0;
		start        = 1'b0;
		luma_first   = '0;
		chroma_blue  = '0;
		luma_second  = '0;
		chroma_red   = '0;
		frame_end_in = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners, back to back
		send_word(8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 0); // all low
		send_word(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 0); // all high
		send_word(8'd0,   8'd128, 8'd255, 8'd128, 1'b0, 0); // zero chroma
		send_word(8'd16,  8'd128, 8'd235, 8'd128, 1'b0, 0); // video levels
		send_word(8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 0); // blue clamps low
		send_word(8'd255, 8'd255, 8'd255, 8'd0,   1'b0, 0); // blue clamps high
		send_word(8'd255, 8'd0,   8'd0,   8'd255, 1'b1, 0); // mixed clamps
		send_word(8'd0,   8'd255, 8'd255, 8'd0,   1'b0, 0);
		send_word(8'd128, 8'd127, 8'd128, 8'd127, 1'b0, 0); // -1 floors to -2
		send_word(8'd128, 8'd129, 8'd128, 8'd129, 1'b0, 0); // +1 terms
		send_word(8'd100, 8'd128, 8'd100, 8'd129, 1'b0, 0);
		send_word(8'd100, 8'd127, 8'd100, 8'd128, 1'b0, 0);
		send_word(8'd1,   8'd128, 8'd254, 8'd128, 1'b0, 0);
		send_word(8'h55,  8'hAA,  8'hAA,  8'h55,  1'b0, 0); // bit toggles
		send_word(8'hAA,  8'h55,  8'h55,  8'hAA,  1'b1, 0);

		// Random phases: full rate, then a drain, then heavy and light idling
		random_words(300, 0);
		drain_pause();
		random_words(300, 72);
		random_words(300, 26);
		start <= 1'b0;

		// Wait out the pipeline, then keep watching for stray strobes
		waited = 0;
		while (sb.pending_rgb.size() != 0 && waited < END_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYC) @(posedge clk);

		if (sb.pending_rgb.size() != 0) begin
			$display("%0d results never arrived", sb.pending_rgb.size());
			$display("TB_ERROR");
			$finish;
		end else begin
			$display("Checked %0d of %0d macropixels (%0d frame ends, %0d clamped channels);",
				sb.pairs_checked, sb.words_in, sb.frame_marks, sb.clamped_channels);
			$display("sender idling at 0, 72 and 26 percent, one full drain; %0d failures.",
				sb.failures);
			if (sb.failures == 0) begin
				$display("TB_OK");
			end else begin
				$display("TB_ERROR");
			end
			$finish;
		end
	end

	// Watchdog, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("Timeout");
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== yuyv_to_rgb888_scaled_unit.f =====
sv/y2rgb_pkg.sv
sv/y2rgb_chroma.sv
sv/y2rgb_back.sv
sv/yuyv_to_rgb888_scaled_unit.sv
test/tb_yuyv_to_rgb888_scaled_unit.sv
